// File: src/fvp_pkg.sv
package fvp_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int DIV_STAGES = 16;
	localparam int XY_W = 33;

	localparam logic [XY_W-1:0] CORDIC_GAIN_Q30 = 33'd652032874;
	localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;
	localparam logic [15:0] BUS_MIN_RAW = 16'd25;
	localparam logic [15:0] BUS_DEFAULT_RAW = 16'd3072;

	localparam logic [7:0] REG_POLE_PAIRS = 8'd0;
	localparam logic [7:0] REG_ANGLE_OFFSET = 8'd1;
	localparam logic [7:0] REG_BUS_VOLTAGE = 8'd2;
	localparam logic [7:0] REG_TIMER_PERIOD = 8'd3;

	localparam logic [31:0] ATAN_TURN32 [CORDIC_STAGES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861
	};

	typedef struct packed {
		logic signed [15:0] volt_q;
		logic signed [15:0] volt_d;
	} vcmd_t;

endpackage

// File: src/fvp_cordic.sv
module fvp_cordic
	import fvp_pkg::*;
(
	input  logic                clk,
	input  logic                en,
	input  logic [31:0]         turn,
	input  vcmd_t               side_in,
	output logic signed [15:0]  cos_out,
	output logic signed [15:0]  sin_out,
	output vcmd_t               side_out
);

	logic signed [XY_W-1:0] x_q [CORDIC_STAGES+1];
	logic signed [XY_W-1:0] y_q [CORDIC_STAGES+1];
	logic signed [XY_W-1:0] z_q [CORDIC_STAGES+1];
	logic [1:0]             quad_q [CORDIC_STAGES+1];
	vcmd_t                  side_q [CORDIC_STAGES+1];

	assign x_q[0] = CORDIC_GAIN_Q30;
	assign y_q[0] = '0;
	assign z_q[0] = {3'b000, turn[29:0]};
	assign quad_q[0] = turn[31:30];
	assign side_q[0] = side_in;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		logic signed [XY_W-1:0] dx, dy, at;
		assign dx = x_q[i] >>> i;
		assign dy = y_q[i] >>> i;
		assign at = {1'b0, ATAN_TURN32[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[i][XY_W-1]) begin
					x_q[i+1] <= x_q[i] - dy;
					y_q[i+1] <= y_q[i] + dx;
					z_q[i+1] <= z_q[i] - at;
				end else begin
					x_q[i+1] <= x_q[i] + dy;
					y_q[i+1] <= y_q[i] - dx;
					z_q[i+1] <= z_q[i] + at;
				end
				quad_q[i+1] <= quad_q[i];
				side_q[i+1] <= side_q[i];
			end
		end
	end

	logic signed [XY_W-1:0] xr, yr;
	logic signed [15:0]     cq, sq;

	assign xr = (x_q[CORDIC_STAGES] + XY_W'(16384)) >>> 15;
	assign yr = (y_q[CORDIC_STAGES] + XY_W'(16384)) >>> 15;

	always_comb begin
		if (xr > XY_W'(32767)) cq = 16'sd32767;
		else if (xr < -XY_W'(32767)) cq = -16'sd32767;
		else cq = xr[15:0];
		if (yr > XY_W'(32767)) sq = 16'sd32767;
		else if (yr < -XY_W'(32767)) sq = -16'sd32767;
		else sq = yr[15:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_q[CORDIC_STAGES])
				2'd0: begin cos_out <= cq;  sin_out <= sq;  end
				2'd1: begin cos_out <= -sq; sin_out <= cq;  end
				2'd2: begin cos_out <= -cq; sin_out <= -sq; end
				default: begin cos_out <= sq; sin_out <= -cq; end
			endcase
			side_out <= side_q[CORDIC_STAGES];
		end
	end

endmodule

// File: src/fvp_div.sv
module fvp_div
	import fvp_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [32:0] dividend,
	input  logic [16:0] divisor,
	output logic [15:0] quotient
);

	logic [16:0] rem_q [DIV_STAGES+1];
	logic [15:0] lo_q  [DIV_STAGES+1];
	logic [15:0] quo_q [DIV_STAGES+1];

	assign rem_q[0] = dividend[32:16];
	assign lo_q[0] = dividend[15:0];
	assign quo_q[0] = '0;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
		logic [17:0] r2, diff;
		logic        ge;
		assign r2 = {rem_q[k], lo_q[k][15]};
		assign ge = r2 >= {1'b0, divisor};
		assign diff = r2 - {1'b0, divisor};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= ge ? diff[16:0] : r2[16:0];
				lo_q[k+1] <= {lo_q[k][14:0], 1'b0};
				quo_q[k+1] <= {quo_q[k][14:0], ge};
			end
		end
	end

	assign quotient = quo_q[DIV_STAGES];

endmodule

// File: src/foc_voltage_to_pwm_compare.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    rotor_angle, volt_q, volt_d
// out      out_valid / out_ready  phase_a/b/c_volt, compare_a/b/c
// cfg      cfg_wr_en              cfg_index, cfg_wdata
//
// One beat enters per cycle unless the output stalls; each beat passes through
// the 16 CORDIC stages and the 16 one-bit compare divider stages.
// Reset clears the valid bits and loads the register defaults.
// A stall at the output freezes every stage at once, so nothing is lost.
module foc_voltage_to_pwm_compare
	import fvp_pkg::*;
#(
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        rotor_angle,
	input  logic signed [15:0] volt_q,
	input  logic signed [15:0] volt_d,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [16:0] phase_a_volt,
	output logic signed [16:0] phase_b_volt,
	output logic signed [16:0] phase_c_volt,
	output logic [15:0]        compare_a,
	output logic [15:0]        compare_b,
	output logic [15:0]        compare_c,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_wdata
);

	localparam int LAT = 24 + DIV_STAGES;
	localparam int VDLY = DIV_STAGES + 2;

	logic [6:0]  pole_pairs_q;
	logic [15:0] angle_offset_q, bus_voltage_q, timer_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_pairs_q <= 7'd7;
			angle_offset_q <= '0;
			bus_voltage_q <= BUS_DEFAULT_RAW;
			timer_period_q <= 16'hFFFF;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_POLE_PAIRS: pole_pairs_q <= cfg_wdata[6:0];
				REG_ANGLE_OFFSET: angle_offset_q <= cfg_wdata;
				REG_BUS_VOLTAGE: bus_voltage_q <= cfg_wdata;
				REG_TIMER_PERIOD: timer_period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic           en;
	logic [LAT-1:0] vld_q;

	assign out_valid = vld_q[LAT-1];
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	logic [39:0]           ang_ext, off_ext;
	logic [ANGLE_BITS-1:0] ang_w, off_w, el;
	logic [ANGLE_BITS+6:0] ang_mul;

	assign ang_ext = {rotor_angle, 24'd0};
	assign off_ext = {angle_offset_q, 24'd0};
	assign ang_w = ang_ext[39 -: ANGLE_BITS];
	assign off_w = off_ext[39 -: ANGLE_BITS];
	assign ang_mul = ang_w * pole_pairs_q;
	assign el = ang_mul[ANGLE_BITS-1:0] - off_w;

	logic [ANGLE_BITS-1:0] el_s1;
	vcmd_t                 cmd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			el_s1 <= el;
			cmd_s1 <= '{volt_q: volt_q, volt_d: volt_d};
		end
	end

	logic signed [15:0] cos_s18, sin_s18;
	vcmd_t              cmd_s18;

	fvp_cordic u_cordic (
		.clk(clk),
		.en(en),
		.turn({el_s1, {(32-ANGLE_BITS){1'b0}}}),
		.side_in(cmd_s1),
		.cos_out(cos_s18),
		.sin_out(sin_s18),
		.side_out(cmd_s18)
	);

	logic signed [31:0] pdc_s19, pqs_s19, pds_s19, pqc_s19;
	logic signed [32:0] alpha_s20, beta_s20, alpha_s21;
	logic signed [50:0] kb_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			pdc_s19 <= cmd_s18.volt_d * cos_s18;
			pqs_s19 <= cmd_s18.volt_q * sin_s18;
			pds_s19 <= cmd_s18.volt_d * sin_s18;
			pqc_s19 <= cmd_s18.volt_q * cos_s18;
			alpha_s20 <= 33'(pdc_s19) - 33'(pqs_s19);
			beta_s20 <= 33'(pds_s19) + 33'(pqc_s19);
			alpha_s21 <= alpha_s20;
			kb_s21 <= 51'(beta_s20) * 51'($signed({1'b0, SQRT3_HALF_Q16}));
		end
	end

	logic signed [51:0] a15, ubw, ucw, ubr, ucr;
	logic signed [32:0] uar;
	logic signed [16:0] ua, ub, uc;

	assign a15 = 52'(alpha_s21) <<< 15;
	assign ubw = 52'(kb_s21) - a15;
	assign ucw = -a15 - 52'(kb_s21);
	assign ubr = (ubw + 52'sd1073741824) >>> 31;
	assign ucr = (ucw + 52'sd1073741824) >>> 31;
	assign uar = (alpha_s21 + 33'sd16384) >>> 15;

	always_comb begin
		if (uar > 33'sd65535) ua = 17'sd65535;
		else if (uar < -33'sd65536) ua = -17'sd65536;
		else ua = uar[16:0];
		if (ubr > 52'sd65535) ub = 17'sd65535;
		else if (ubr < -52'sd65536) ub = -17'sd65536;
		else ub = ubr[16:0];
		if (ucr > 52'sd65535) uc = 17'sd65535;
		else if (ucr < -52'sd65536) uc = -17'sd65536;
		else uc = ucr[16:0];
	end

	logic signed [16:0] u_s22 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			u_s22[0] <= ua;
			u_s22[1] <= ub;
			u_s22[2] <= uc;
		end
	end

	logic [15:0] vbus;
	logic [16:0] dvs;

	assign vbus = (bus_voltage_q <= BUS_MIN_RAW) ? BUS_DEFAULT_RAW : bus_voltage_q;
	assign dvs = {vbus, 1'b0};

	logic signed [16:0] vdly_q [VDLY][3];

	always_ff @(posedge clk) begin
		if (en) begin
			vdly_q[0] <= u_s22;
			for (int k = 1; k < VDLY; k++) vdly_q[k] <= vdly_q[k-1];
		end
	end

	for (genvar p = 0; p < 3; p++) begin : g_phase
		logic signed [18:0] nraw;
		logic [16:0]        n_s23;
		logic [32:0]        prod_s24;
		assign nraw = ($signed({u_s22[p][16], u_s22[p], 1'b0})) + $signed({3'b000, vbus});
		always_ff @(posedge clk) begin
			if (en) begin
				if (nraw[18]) n_s23 <= '0;
				else if (nraw[17:0] > {1'b0, dvs}) n_s23 <= dvs;
				else n_s23 <= nraw[16:0];
				prod_s24 <= n_s23 * timer_period_q;
			end
		end
		logic [15:0] quo;
		fvp_div u_div (
			.clk(clk),
			.en(en),
			.dividend(prod_s24),
			.divisor(dvs),
			.quotient(quo)
		);
		if (p == 0) begin : g_a
			assign compare_a = quo;
		end else if (p == 1) begin : g_b
			assign compare_b = quo;
		end else begin : g_c
			assign compare_c = quo;
		end
	end

	assign phase_a_volt = vdly_q[VDLY-1][0];
	assign phase_b_volt = vdly_q[VDLY-1][1];
	assign phase_c_volt = vdly_q[VDLY-1][2];

endmodule

// File: tb/foc_voltage_to_pwm_compare_tb.sv
`timescale 1ns / 100ps

module foc_voltage_to_pwm_compare_tb
	import fvp_pkg::*;
();

	localparam int LATENCY = 40;

	typedef struct packed {
		logic signed [16:0] ua;
		logic signed [16:0] ub;
		logic signed [16:0] uc;
		logic [15:0] ca;
		logic [15:0] cb;
		logic [15:0] cc;
	} phase_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] rotor_angle = '0;
	logic signed [15:0] volt_q = '0;
	logic signed [15:0] volt_d = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [16:0] phase_a_volt, phase_b_volt, phase_c_volt;
	logic [15:0] compare_a, compare_b, compare_c;
	logic cfg_wr_en = 1'b0;
	logic [7:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	logic [6:0] m_pole_pairs;
	logic [15:0] m_angle_offset, m_bus_voltage, m_timer_period;

	phase_out_t pending_phases[$];
	int errors = 0;
	bit sending_done = 0;

	foc_voltage_to_pwm_compare u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("foc_voltage_to_pwm_compare test failed");
		$finish;
	end

	function automatic longint asr64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [15:0] duty_count(longint u, longint vbus);
		longint n;
		n = clip(2 * u + vbus, 0, 2 * vbus);
		return 16'((n * longint'(m_timer_period)) / (2 * vbus));
	endfunction

	function automatic phase_out_t predict_phases(logic [15:0] ang, logic signed [15:0] vq,
			logic signed [15:0] vd);
		logic [15:0] el;
		logic [31:0] turn;
		longint x, y, z, dx, dy, cq, sq, s, c, alpha, beta, ua, ub, uc, vbus;
		phase_out_t r;
		el = 16'(ang * m_pole_pairs - m_angle_offset);
		turn = {el, 16'd0};
		x = 652032874;
		y = 0;
		z = longint'(turn[29:0]);
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = asr64(x, i);
			dy = asr64(y, i);
			if (z >= 0) begin
				x -= dy; y += dx; z -= longint'(ATAN_TURN32[i]);
			end else begin
				x += dy; y -= dx; z += longint'(ATAN_TURN32[i]);
			end
		end
		cq = clip(rnd_shift(x, 15), -32767, 32767);
		sq = clip(rnd_shift(y, 15), -32767, 32767);
		case (turn[31:30])
			2'd0: begin c = cq; s = sq; end
			2'd1: begin c = -sq; s = cq; end
			2'd2: begin c = -cq; s = -sq; end
			default: begin c = sq; s = -cq; end
		endcase
		alpha = longint'(vd) * c - longint'(vq) * s;
		beta = longint'(vd) * s + longint'(vq) * c;
		ua = clip(rnd_shift(alpha, 15), -65536, 65535);
		ub = clip(rnd_shift(-alpha * 32768 + 56756 * beta, 31), -65536, 65535);
		uc = clip(rnd_shift(-alpha * 32768 - 56756 * beta, 31), -65536, 65535);
		vbus = (m_bus_voltage <= BUS_MIN_RAW) ? 3072 : longint'(m_bus_voltage);
		r.ua = 17'(ua);
		r.ub = 17'(ub);
		r.uc = 17'(uc);
		r.ca = duty_count(ua, vbus);
		r.cb = duty_count(ub, vbus);
		r.cc = duty_count(uc, vbus);
		return r;
	endfunction

	task automatic write_reg(logic [7:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_POLE_PAIRS: m_pole_pairs = val[6:0];
			REG_ANGLE_OFFSET: m_angle_offset = val;
			REG_BUS_VOLTAGE: m_bus_voltage = val;
			REG_TIMER_PERIOD: m_timer_period = val;
			default: ;
		endcase
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_phases.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic send_command(logic [15:0] ang, logic [15:0] vq, logic [15:0] vd);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rotor_angle <= ang;
		volt_q <= vq;
		volt_d <= vd;
		pending_phases.push_back(predict_phases(ang, vq, vd));
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [15:0] edge_val();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic [15:0] v [6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0100, 16'h4000};
		for (int i = 0; i < 6; i++)
			send_command(16'(i * 13107), v[i], v[5 - i]);
		send_command(16'h4000, 16'h7FFF, 16'h7FFF);
		send_command(16'hC000, 16'h8000, 16'h8000);
		send_command(16'hFFFF, 16'h8000, 16'h7FFF);
		send_command(16'h2000, 16'h0C00, 16'h0000);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_command(16'($urandom), ($urandom_range(0, 1) ? edge_val() : 16'($urandom)),
				($urandom_range(0, 1) ? edge_val() : 16'($urandom)));
	endtask

	task automatic test_settings();
		logic [15:0] bus_pick [5] = '{16'd0, 16'd25, 16'd26, 16'hFFFF, 16'd3072};
		logic [15:0] per_pick [3] = '{16'd0, 16'hFFFF, 16'd1000};
		logic [6:0] pp_pick [5] = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd7};
		for (int k = 0; k < 5; k++) begin
			drain_pipeline();
			write_reg(REG_POLE_PAIRS, 16'(pp_pick[k]));
			write_reg(REG_ANGLE_OFFSET, (k == 4) ? 16'($urandom) : edge_val());
			write_reg(REG_BUS_VOLTAGE, bus_pick[k]);
			write_reg(REG_TIMER_PERIOD, per_pick[k % 3]);
			write_reg(8'd9, 16'($urandom));
			test_directed();
			test_random(350);
		end
	endtask

	always @(posedge clk) begin
		phase_out_t want;
		if (out_valid && out_ready) begin
			if (pending_phases.size() == 0) begin
				$display("%0t: unexpected beat", $time);
				errors++;
			end else begin
				want = pending_phases.pop_front();
				if (want !== {phase_a_volt, phase_b_volt, phase_c_volt,
						compare_a, compare_b, compare_c}) begin
					$display("%0t: expected %h %h %h %h %h %h, actual %h %h %h %h %h %h",
						$time, want.ua, want.ub, want.uc, want.ca, want.cb, want.cc,
						phase_a_volt, phase_b_volt, phase_c_volt,
						compare_a, compare_b, compare_c);
					errors++;
				end
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!sending_done && $urandom_range(0, 3) == 0)
					stall = $urandom_range(0, 19);
			end
		end
	end

	initial begin
		m_pole_pairs = 7;
		m_angle_offset = 0;
		m_bus_voltage = 3072;
		m_timer_period = 65535;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(150);
		test_settings();
		sending_done = 1;
		drain_pipeline();
		if (errors == 0 && pending_phases.size() == 0)
			$display("foc_voltage_to_pwm_compare test passed");
		else
			$display("foc_voltage_to_pwm_compare test failed");
		$finish;
	end

endmodule
